@@ rtl/cdlm_pkg.sv @@
// Shared types and constants for the calendar date-list matcher.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cdlm_pkg;

	// Calendar and list sizing
	localparam int NUM_CALENDARS = 4;
	localparam int MAX_ENTRIES   = 16;
	localparam int CAL_W  = (NUM_CALENDARS > 1) ? $clog2(NUM_CALENDARS) : 1;
	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int DEPTH  = NUM_CALENDARS * MAX_ENTRIES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Packed date arithmetic: (year + 1900) * 10000 + month * 100 + day
	localparam int PACK_W      = 25;
	localparam int YEAR_W      = 12;
	localparam int YEAR_BASE   = 1900;
	localparam int YEAR_SCALE  = 10000;
	localparam int MONTH_SCALE = 100;

	localparam logic [7:0] WILDCARD = 8'hFF;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_EVAL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_DATE  = 2'd0,
		KIND_RANGE = 2'd1,
		KIND_WEEK  = 2'd2,
		KIND_NEVER = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] yr;
		logic [7:0] mon;
		logic [7:0] day;
	} date_t;

	typedef struct packed {
		kind_t      kind;
		date_t      start;
		date_t      stop;
		logic [7:0] wday;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_req_t;

	typedef struct packed {
		logic ge;
		logic le;
	} cmp_t;

endpackage

`default_nettype wire

@@ rtl/cdlm_date_pack.sv @@
// Shared date unit: packs year/month/day into one number and compares it
// against the packed date under test. Depends on cdlm_pkg.
`default_nettype none

module cdlm_date_pack (
	input  wire cdlm_pkg::date_t              dt,
	input  wire [cdlm_pkg::PACK_W-1:0]        cur_val,
	output logic [cdlm_pkg::PACK_W-1:0]       pack_val,
	output cdlm_pkg::cmp_t                    cmp
);
	import cdlm_pkg::*;

	logic [YEAR_W-1:0] year_full;

	// Rebase the year offset
	assign year_full = YEAR_W'(dt.yr) + YEAR_W'(YEAR_BASE);

	// Pack the date
	assign pack_val = PACK_W'(year_full) * PACK_W'(YEAR_SCALE)
	                + PACK_W'(dt.mon) * PACK_W'(MONTH_SCALE)
	                + PACK_W'(dt.day);

	// Compare the tested date against this one
	assign cmp.ge = (cur_val >= pack_val);
	assign cmp.le = (cur_val <= pack_val);

endmodule

`default_nettype wire

@@ rtl/cdlm_entry_ram.sv @@
// Entry store: one write port and one registered read port holding every
// calendar's date entries. Depends on cdlm_pkg.
`default_nettype none

module cdlm_entry_ram (
	input  wire                      clk,
	input  wire cdlm_pkg::ram_req_t  req,
	output cdlm_pkg::entry_t         rd_data
);
	import cdlm_pkg::*;

	entry_t mem [DEPTH];

	// Write on request, register the read data
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/calendar_date_list_matcher.sv @@
// Top level of the calendar date-list matcher: command port, scan sequencer,
// per-calendar counts and present values. Depends on cdlm_pkg, cdlm_entry_ram
// and cdlm_date_pack.
//
//   channel   signals                                    handshake
//   command   operation calendar entry_kind date_* end_* start / busy
//             weekday
//   result    accepted cal_active list_size              done, one cycle
//
// Clear, append, an invalid calendar and operation three finish in the cycle
// of acceptance; the result strobes in the following cycle and busy stays low.
// Evaluate keeps busy high while it packs the tested date (S_CUR) and scans entries
// in order up to the first hit or the list end, a single-date, weekday or never entry
// in S_CHECK and a range entry in S_CHECK then S_HI, through the single entry-store read
// port and the one shared pack/compare unit; the result strobes as busy falls.
// Reset clears counts and present values; the entry store needs no clearing.
// The receiver takes each result in its strobe cycle and cannot stall.
`default_nettype none

module calendar_date_list_matcher (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire [1:0]  operation,
	input  wire [2:0]  calendar,
	input  wire [1:0]  entry_kind,
	input  wire [7:0]  date_year,
	input  wire [7:0]  date_month,
	input  wire [7:0]  date_day,
	input  wire [7:0]  end_year,
	input  wire [7:0]  end_month,
	input  wire [7:0]  end_day,
	input  wire [7:0]  weekday,
	output logic       done,
	output logic       accepted,
	output logic       cal_active,
	output logic [4:0] list_size
);
	import cdlm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CUR,
		S_CHECK,
		S_HI
	} state_t;

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [CAL_W-1:0] cal,
	                                                 input logic [IDX_W-1:0] idx);
		return ADDR_W'(cal) * ADDR_W'(MAX_ENTRIES) + ADDR_W'(idx);
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q [NUM_CALENDARS];
	logic              pv_q [NUM_CALENDARS];
	logic [CAL_W-1:0]  cal_q;
	date_t             test_q;
	logic [7:0]        twd_q;
	logic [PACK_W-1:0] cur_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              ge_q;
	logic              done_q;
	logic              accepted_q;
	logic              present_q;
	logic [4:0]        count_out_q;

	logic              accept;
	logic              cal_ok;
	logic [CAL_W-1:0]  cal_idx;
	logic [CNT_W-1:0]  cur_cnt;
	logic              room;
	op_t               op;
	entry_t            ent;
	ram_req_t          ram_req;
	date_t             unit_in;
	logic [PACK_W-1:0] pack_val;
	cmp_t              cmp;
	logic [7:0]        start_yr;
	logic [7:0]        stop_yr;
	logic              entry_hit;
	logic              hit_hi;
	logic              step_miss;
	logic [CNT_W-1:0]  nxt_idx;
	logic              more;
	logic              scan_hit;
	logic              scan_done;

	// Decode the command
	assign accept  = start && !busy;
	assign cal_ok  = ({1'b0, calendar} < 4'(NUM_CALENDARS));
	assign cal_idx = calendar[CAL_W-1:0];
	assign cur_cnt = cnt_q[cal_idx];
	assign room    = (cur_cnt < CNT_W'(MAX_ENTRIES));
	assign op      = op_t'(operation);

	// Resolve wildcard years of a range entry to the tested year
	assign start_yr = (ent.start.yr == WILDCARD) ? test_q.yr : ent.start.yr;
	assign stop_yr  = (ent.stop.yr == WILDCARD) ? test_q.yr : ent.stop.yr;

	// Steer the shared pack/compare unit
	always_comb begin
		unique case (state_q)
			S_CHECK: unit_in = '{yr: start_yr, mon: ent.start.mon, day: ent.start.day};
			S_HI:    unit_in = '{yr: stop_yr, mon: ent.stop.mon, day: ent.stop.day};
			S_IDLE,
			S_CUR:   unit_in = test_q;
		endcase
	end

	cdlm_date_pack u_pack (
		.dt       (unit_in),
		.cur_val  (cur_q),
		.pack_val (pack_val),
		.cmp      (cmp)
	);

	// Match the current entry
	always_comb begin
		unique case (ent.kind)
			KIND_DATE: entry_hit = ((ent.start.yr == WILDCARD) || (ent.start.yr == test_q.yr))
			                    && ((ent.start.mon == WILDCARD) || (ent.start.mon == test_q.mon))
			                    && ((ent.start.day == WILDCARD) || (ent.start.day == test_q.day));
			KIND_WEEK: entry_hit = ((ent.start.mon == WILDCARD) || (ent.start.mon == test_q.mon))
			                    && ((ent.wday == WILDCARD) || (ent.wday == twd_q));
			KIND_RANGE,
			KIND_NEVER: entry_hit = 1'b0;
		endcase
	end

	assign hit_hi    = ge_q && cmp.le;
	assign step_miss = ((state_q == S_CHECK) && (ent.kind != KIND_RANGE) && !entry_hit)
	                || ((state_q == S_HI) && !hit_hi);
	assign nxt_idx   = CNT_W'(idx_q) + CNT_W'(1);
	assign more      = (nxt_idx < scan_cnt_q);
	assign scan_hit  = ((state_q == S_CHECK) && (ent.kind != KIND_RANGE) && entry_hit)
	                || ((state_q == S_HI) && hit_hi);
	assign scan_done = ((state_q == S_CUR) && (scan_cnt_q == '0))
	                || scan_hit || (step_miss && !more);

	// Drive the entry store: append writes, scan reads
	always_comb begin
		ram_req.wr_en        = accept && cal_ok && (op == OP_APPEND) && room;
		ram_req.wr_addr      = entry_addr(cal_idx, cur_cnt[IDX_W-1:0]);
		ram_req.wr_data.kind = kind_t'(entry_kind);
		ram_req.wr_data.start = '{yr: date_year, mon: date_month, day: date_day};
		ram_req.wr_data.stop  = '{yr: end_year, mon: end_month, day: end_day};
		ram_req.wr_data.wday = weekday;
		ram_req.rd_en        = ((state_q == S_CUR) && (scan_cnt_q != '0))
		                    || (step_miss && more);
		ram_req.rd_addr      = (state_q == S_CUR) ? entry_addr(cal_q, '0)
		                                          : entry_addr(cal_q, nxt_idx[IDX_W-1:0]);
	end

	cdlm_entry_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ent)
	);

	// Sequence commands, hold calendar state and the result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			for (int i = 0; i < NUM_CALENDARS; i++) begin
				cnt_q[i] <= '0;
				pv_q[i]  <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cal_q  <= cal_idx;
						test_q <= '{yr: date_year, mon: date_month, day: date_day};
						twd_q  <= weekday;
						if (!cal_ok) begin
							done_q      <= 1'b1;
							accepted_q  <= 1'b0;
							present_q   <= 1'b0;
							count_out_q <= '0;
						end else begin
							unique case (op)
								OP_CLEAR: begin
									cnt_q[cal_idx] <= '0;
									done_q         <= 1'b1;
									accepted_q     <= 1'b1;
									present_q      <= pv_q[cal_idx];
									count_out_q    <= '0;
								end
								OP_APPEND: begin
									done_q    <= 1'b1;
									present_q <= pv_q[cal_idx];
									if (room) begin
										cnt_q[cal_idx] <= cur_cnt + CNT_W'(1);
										accepted_q     <= 1'b1;
										count_out_q    <= 5'(cur_cnt + CNT_W'(1));
									end else begin
										accepted_q  <= 1'b0;
										count_out_q <= 5'(cur_cnt);
									end
								end
								OP_EVAL: begin
									scan_cnt_q <= cur_cnt;
									idx_q      <= '0;
									state_q    <= S_CUR;
								end
								OP_NONE: begin
									done_q      <= 1'b1;
									accepted_q  <= 1'b0;
									present_q   <= pv_q[cal_idx];
									count_out_q <= 5'(cur_cnt);
								end
							endcase
						end
					end
				end
				S_CUR,
				S_CHECK,
				S_HI: begin
					if (state_q == S_CUR) begin
						cur_q <= pack_val;
					end
					if (scan_done) begin
						// Store the verdict and report
						pv_q[cal_q] <= scan_hit;
						done_q      <= 1'b1;
						accepted_q  <= 1'b1;
						present_q   <= scan_hit;
						count_out_q <= 5'(scan_cnt_q);
						state_q     <= S_IDLE;
					end else if (state_q == S_CUR) begin
						state_q <= S_CHECK;
					end else if ((state_q == S_CHECK) && (ent.kind == KIND_RANGE)) begin
						ge_q    <= cmp.ge;
						state_q <= S_HI;
					end else begin
						// Advance to the next entry
						idx_q   <= nxt_idx[IDX_W-1:0];
						state_q <= S_CHECK;
					end
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign accepted   = accepted_q;
	assign cal_active = present_q;
	assign list_size  = count_out_q;

`ifndef SYNTHESIS
	// A result only appears once the scan has ended
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An evaluate on a valid calendar starts a scan
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cal_ok && (op == OP_EVAL)) |=> busy)
		else $error("evaluate did not start a scan");

	// The scan never reads past the list
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHECK) || (state_q == S_HI)) |-> (CNT_W'(idx_q) < scan_cnt_q))
		else $error("scan index beyond entry count");
`endif

endmodule

`default_nettype wire

@@ verif/tb_calendar_date_list_matcher.sv @@
// Self-checking testbench for the calendar date-list matcher: a queue-fed driver issues
// clear, append and evaluate transactions and a monitor checks every result strobe
// against an in-bench calendar model. Depends on cdlm_pkg and calendar_date_list_matcher.
module tb_calendar_date_list_matcher;
	timeunit 1ns;
	timeprecision 1ps;
	import cdlm_pkg::*;

	localparam int LIVE_TARGET   = 1800;
	localparam int QUIET_TAIL    = 150;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic       drain;
		op_t        op;
		logic [2:0] cal;
		kind_t      kind;
		date_t      dt;
		date_t      stop;
		logic [7:0] wday;
	} cmd_t;

	typedef struct packed {
		logic       acc;
		logic       pv;
		logic [4:0] cnt;
	} status_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic [1:0] operation  = '0;
	logic [2:0] calendar   = '0;
	logic [1:0] entry_kind = '0;
	logic [7:0] date_year  = '0;
	logic [7:0] date_month = '0;
	logic [7:0] date_day   = '0;
	logic [7:0] end_year   = '0;
	logic [7:0] end_month  = '0;
	logic [7:0] end_day    = '0;
	logic [7:0] weekday    = '0;
	logic       busy;
	logic       done;
	logic       accepted;
	logic       cal_active;
	logic [4:0] list_size;

	// Calendar model state
	entry_t      cal_list  [NUM_CALENDARS][MAX_ENTRIES];
	int unsigned cal_count [NUM_CALENDARS];
	logic        cal_pv    [NUM_CALENDARS];

	cmd_t    cmd_backlog [$];
	status_t status_due  [$];
	cmd_t    on_bus;
	status_t want;
	logic    raise;
	int      idle_left;
	int      idle_pct = 20;
	int      presented;
	int      quiet_from;
	int      bad_fields;
	int      live_items;

	calendar_date_list_matcher i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] rnd8(int lo, int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic logic [7:0] wild(logic [7:0] v, int pct);
		return ($urandom_range(0, 99) < pct) ? WILDCARD : v;
	endfunction

	function automatic int unsigned date_key(logic [7:0] y, logic [7:0] m, logic [7:0] d);
		int unsigned yu, mu, du;
		yu = y;
		mu = m;
		du = d;
		return (yu + YEAR_BASE) * YEAR_SCALE + mu * MONTH_SCALE + du;
	endfunction

	function automatic bit entry_hits(entry_t e, date_t t, logic [7:0] wd);
		logic [7:0] sy, ey;
		int unsigned now_key, lo_key, hi_key;
		case (e.kind)
			KIND_DATE: begin
				return (e.start.yr == WILDCARD || e.start.yr == t.yr) &&
					(e.start.mon == WILDCARD || e.start.mon == t.mon) &&
					(e.start.day == WILDCARD || e.start.day == t.day);
			end
			KIND_RANGE: begin
				// a wildcard year on either end stands for the tested year
				sy = (e.start.yr == WILDCARD) ? t.yr : e.start.yr;
				ey = (e.stop.yr == WILDCARD) ? t.yr : e.stop.yr;
				now_key = date_key(t.yr, t.mon, t.day);
				lo_key  = date_key(sy, e.start.mon, e.start.day);
				hi_key  = date_key(ey, e.stop.mon, e.stop.day);
				return now_key >= lo_key && now_key <= hi_key;
			end
			KIND_WEEK: begin
				return (e.start.mon == WILDCARD || e.start.mon == t.mon) &&
					(e.wday == WILDCARD || e.wday == wd);
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic entry_t entry_of(cmd_t c);
		entry_t e;
		e.kind  = c.kind;
		e.start = c.dt;
		e.stop  = c.stop;
		e.wday  = c.wday;
		return e;
	endfunction

	// Apply one transaction to the calendar model and return the status it produces
	function automatic status_t apply_calendar_cmd(cmd_t c);
		status_t r;
		bit      hit;
		r = '0;
		if (c.cal < NUM_CALENDARS) begin
			case (c.op)
				OP_CLEAR: begin
					cal_count[c.cal] = 0;
					r.acc = 1'b1;
				end
				OP_APPEND: begin
					if (cal_count[c.cal] < MAX_ENTRIES) begin
						cal_list[c.cal][cal_count[c.cal]] = entry_of(c);
						cal_count[c.cal]++;
						r.acc = 1'b1;
					end
				end
				OP_EVAL: begin
					hit = 1'b0;
					for (int i = 0; i < cal_count[c.cal]; i++)
						if (!hit && entry_hits(cal_list[c.cal][i], c.dt, c.wday))
							hit = 1'b1;
					cal_pv[c.cal] = hit;
					r.acc = 1'b1;
				end
				default: ;
			endcase
			r.pv  = cal_pv[c.cal];
			r.cnt = 5'(cal_count[c.cal]);
		end
		return r;
	endfunction

	function automatic cmd_t mk(op_t op, int cal, kind_t kind, int y, int m, int d,
			int ey, int em, int ed, int wd);
		cmd_t c;
		c.drain     = 1'b0;
		c.op        = op;
		c.cal       = 3'(cal);
		c.kind      = kind;
		c.dt.yr     = 8'(y);
		c.dt.mon    = 8'(m);
		c.dt.day    = 8'(d);
		c.stop.yr   = 8'(ey);
		c.stop.mon  = 8'(em);
		c.stop.day  = 8'(ed);
		c.wday      = 8'(wd);
		return c;
	endfunction

	// Plausible calendar dates with random content
	function automatic cmd_t rand_cmd(op_t op, logic [2:0] cal);
		cmd_t c;
		c.drain    = 1'b0;
		c.op       = op;
		c.cal      = cal;
		c.kind     = kind_t'(2'($urandom_range(0, 3)));
		c.dt.yr    = rnd8(0, 254);
		c.dt.mon   = rnd8(1, 12);
		c.dt.day   = rnd8(1, 31);
		c.stop.yr  = rnd8(0, 254);
		c.stop.mon = rnd8(1, 12);
		c.stop.day = rnd8(1, 31);
		c.wday     = rnd8(1, 7);
		return c;
	endfunction

	function automatic cmd_t new_entry(logic [2:0] cal);
		cmd_t c;
		c = rand_cmd(OP_APPEND, cal);
		c.dt.yr  = wild(c.dt.yr, 20);
		c.dt.mon = wild(c.dt.mon, 20);
		c.dt.day = wild(c.dt.day, 20);
		c.wday   = wild(c.wday, 30);
		// keep most ranges short and forward so that they can be hit
		if (c.kind == KIND_RANGE)
			c.stop.yr = wild((c.dt.yr > 250) ? c.dt.yr : c.dt.yr + rnd8(0, 3), 25);
		return c;
	endfunction

	// Build a test date aimed at a given entry
	function automatic cmd_t eval_near(logic [2:0] cal, entry_t e);
		cmd_t  c;
		date_t pick;
		c = rand_cmd(OP_EVAL, cal);
		pick = (e.kind == KIND_RANGE && $urandom_range(0, 1)) ? e.stop : e.start;
		if (pick.yr != WILDCARD)
			c.dt.yr = pick.yr;
		if (pick.mon != WILDCARD)
			c.dt.mon = pick.mon;
		if (pick.day != WILDCARD)
			c.dt.day = pick.day;
		if (e.wday != WILDCARD)
			c.wday = e.wday;
		return c;
	endfunction

	task automatic queue_cmd(cmd_t c);
		cmd_backlog.push_back(c);
		if (c.op != OP_NONE && c.cal < NUM_CALENDARS)
			live_items++;
	endtask

	// Present the next transaction once the block takes the current one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			operation  <= '0;
			calendar   <= '0;
			entry_kind <= '0;
			date_year  <= '0;
			date_month <= '0;
			date_day   <= '0;
			end_year   <= '0;
			end_month  <= '0;
			end_day    <= '0;
			weekday    <= '0;
			foreach (cal_count[i]) begin
				cal_count[i] = 0;
				cal_pv[i]    = 1'b0;
			end
			idle_left = 0;
		end else begin
			raise = start;
			if (start && !busy) begin
				status_due.push_back(apply_calendar_cmd(on_bus));
				raise = 1'b0;
			end
			if (!raise) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (cmd_backlog.size() > 0 &&
						!(cmd_backlog[0].drain && status_due.size() > 0)) begin
					on_bus = cmd_backlog.pop_front();
					operation  <= on_bus.op;
					calendar   <= on_bus.cal;
					entry_kind <= on_bus.kind;
					date_year  <= on_bus.dt.yr;
					date_month <= on_bus.dt.mon;
					date_day   <= on_bus.dt.day;
					end_year   <= on_bus.stop.yr;
					end_month  <= on_bus.stop.mon;
					end_day    <= on_bus.stop.day;
					weekday    <= on_bus.wday;
					raise = 1'b1;
					presented++;
					// switch between busy, sparse and gap-free stretches
					if (presented % 64 == 0) begin
						case ($urandom_range(0, 2))
							0: idle_pct = 0;
							1: idle_pct = 15;
							default: idle_pct = 50;
						endcase
					end
					if (presented < quiet_from && $urandom_range(0, 99) < idle_pct)
						idle_left = $urandom_range(1, 14);
				end
			end
			start <= raise;
		end
	end

	// Check each result strobe against the oldest outstanding status
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (status_due.size() == 0) begin
				$error("result with no transaction outstanding: accepted %0d %s %0d %s %0d",
					accepted, "cal_active", cal_active, "list_size", list_size);
				bad_fields++;
			end else begin
				want = status_due.pop_front();
				if (accepted !== want.acc) begin
					$error("accepted: expected %0d, got %0d", want.acc, accepted);
					bad_fields++;
				end
				if (cal_active !== want.pv) begin
					$error("cal_active: expected %0d, got %0d", want.pv, cal_active);
					bad_fields++;
				end
				if (list_size !== want.cnt) begin
					$error("list_size: expected %0d, got %0d", want.cnt, list_size);
					bad_fields++;
				end
			end
		end
	end

	initial begin
		cmd_t       c;
		entry_t     made [$];
		logic [2:0] cal;
		int         n;

		// Directed: empty list, wildcards, ranges, weekday, never, invalid, ignored
		queue_cmd(mk(OP_EVAL,   0, KIND_DATE,  124, 3, 15, 0, 0, 0, 5));
		queue_cmd(mk(OP_APPEND, 0, KIND_DATE,  124, 3, 15, 0, 0, 0, 255));
		queue_cmd(mk(OP_EVAL,   0, KIND_DATE,  124, 3, 15, 0, 0, 0, 5));
		queue_cmd(mk(OP_EVAL,   0, KIND_DATE,  124, 3, 16, 0, 0, 0, 5));
		queue_cmd(mk(OP_APPEND, 0, KIND_DATE,  255, 255, 255, 255, 255, 255, 255));
		queue_cmd(mk(OP_EVAL,   0, KIND_NEVER, 0, 0, 0, 255, 255, 255, 0));
		// clear keeps the present value; hold until the block has drained
		c = mk(OP_CLEAR, 0, KIND_DATE, 0, 0, 0, 0, 0, 0, 0);
		c.drain = 1'b1;
		queue_cmd(c);
		queue_cmd(mk(OP_APPEND, 1, KIND_RANGE, 255, 1, 1, 255, 12, 31, 0));
		queue_cmd(mk(OP_EVAL,   1, KIND_DATE,  200, 6, 15, 0, 0, 0, 3));
		queue_cmd(mk(OP_EVAL,   1, KIND_DATE,  255, 255, 255, 0, 0, 0, 255));
		queue_cmd(mk(OP_APPEND, 1, KIND_RANGE, 0, 0, 0, 254, 255, 255, 0));
		queue_cmd(mk(OP_EVAL,   1, KIND_DATE,  255, 255, 255, 0, 0, 0, 255));
		queue_cmd(mk(OP_EVAL,   1, KIND_DATE,  0, 0, 0, 0, 0, 0, 0));
		queue_cmd(mk(OP_APPEND, 1, KIND_RANGE, 100, 5, 5, 100, 5, 4, 0));
		queue_cmd(mk(OP_APPEND, 2, KIND_WEEK,  0, 255, 0, 0, 0, 0, 7));
		queue_cmd(mk(OP_EVAL,   2, KIND_DATE,  50, 9, 9, 0, 0, 0, 7));
		queue_cmd(mk(OP_EVAL,   2, KIND_DATE,  50, 9, 9, 0, 0, 0, 1));
		queue_cmd(mk(OP_APPEND, 3, KIND_NEVER, 255, 255, 255, 255, 255, 255, 255));
		queue_cmd(mk(OP_EVAL,   3, KIND_DATE,  255, 255, 255, 255, 255, 255, 255));
		queue_cmd(mk(OP_APPEND, 7, KIND_DATE,  1, 1, 1, 1, 1, 1, 1));
		queue_cmd(mk(OP_EVAL,   4, KIND_DATE,  1, 1, 1, 1, 1, 1, 1));
		queue_cmd(mk(OP_NONE,   1, KIND_RANGE, 9, 9, 9, 9, 9, 9, 9));
		queue_cmd(mk(OP_NONE,   5, KIND_WEEK,  9, 9, 9, 9, 9, 9, 9));
		queue_cmd(mk(OP_CLEAR,  6, KIND_DATE,  0, 0, 0, 0, 0, 0, 0));

		// Random: mostly clear / fill / evaluate sequences, the rest raw noise
		while (live_items < LIVE_TARGET) begin
			if ($urandom_range(0, 99) < 85) begin
				cal = 3'($urandom_range(0, NUM_CALENDARS - 1));
				made.delete();
				if ($urandom_range(0, 99) < 85) begin
					c = mk(OP_CLEAR, cal, KIND_DATE, 0, 0, 0, 0, 0, 0, 0);
					c.drain = ($urandom_range(0, 99) < 3);
					queue_cmd(c);
				end
				// now and then run past a full list
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 3)
					: $urandom_range(0, 6);
				repeat (n) begin
					c = new_entry(cal);
					queue_cmd(c);
					made.push_back(entry_of(c));
				end
				repeat ($urandom_range(1, 4)) begin
					if (made.size() > 0 && $urandom_range(0, 99) < 75)
						c = eval_near(cal, made[$urandom_range(0, made.size() - 1)]);
					else
						c = rand_cmd(OP_EVAL, cal);
					queue_cmd(c);
				end
			end else begin
				c = mk(op_t'(2'($urandom_range(0, 3))), $urandom_range(0, 7),
					kind_t'(2'($urandom_range(0, 3))),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
				queue_cmd(c);
			end
		end
		quiet_from = cmd_backlog.size() - QUIET_TAIL;

		// Single reset at the start of the run
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the backlog and all outstanding results, then let the block settle
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || status_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_fields == 0)
			$display("tb_calendar_date_list_matcher: PASS");
		else
			$display("tb_calendar_date_list_matcher: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("tb_calendar_date_list_matcher: FAIL");
		$finish;
	end

endmodule
